@@ sv/tpl_pkg.sv @@
// ----------------------------------------------------------------------------
// tpl_pkg
// shared constants, command codes and the queue entry type of the tuner
// synthesizer serial loader
// ----------------------------------------------------------------------------
package tpl_pkg;

  localparam int DIVIDER_BITS   = 15;
  localparam int LEAD_ZERO_BITS = 10;

  localparam int FREQ_W   = 22;
  localparam int CMD_W    = 3;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 2;
  localparam int STATUS_W = 8;

  // freq / 200 = (freq >> 3) / 25, done as a multiply by a rounded-up reciprocal
  localparam int DIVQ_IN_W  = FREQ_W - 3;
  localparam int RECIP_W    = 20;
  localparam int RECIP_SH   = 24;
  localparam logic [RECIP_W-1:0] RECIP_25 = RECIP_W'(671089);
  localparam int PROD_W     = DIVQ_IN_W + RECIP_W;
  localparam int QUOT_W     = 15;
  localparam int DIV_FULL_W = 16;
  localparam logic [DIV_FULL_W-1:0] DIV_OFFSET = DIV_FULL_W'(856);
  localparam int DIV_EXT_W  = (DIVIDER_BITS > DIV_FULL_W) ? DIVIDER_BITS : DIV_FULL_W;

  // serializer steps: preamble, lead zeros, divider bits, trailer
  localparam int TRAIL_STEP_I = LEAD_ZERO_BITS + DIVIDER_BITS + 1;
  localparam int STEP_W       = $clog2(TRAIL_STEP_I + 1);

  localparam logic [CMD_W-1:0] CMD_SET_FREQ  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MUTE      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UNMUTE    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ_SIG  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_FREQ = 3'd4;

  localparam logic [BYTE_W-1:0] PRE_BYTE_A  = 8'hc8;
  localparam logic [BYTE_W-1:0] PRE_BYTE_B  = 8'hc9;
  localparam logic [BYTE_W-1:0] TRAIL_BYTE  = 8'hc8;
  localparam logic [BYTE_W-1:0] ZERO_OUTER  = 8'd1;
  localparam logic [BYTE_W-1:0] ZERO_INNER  = 8'd3;
  localparam logic [BYTE_W-1:0] ONE_OUTER   = 8'd5;
  localparam logic [BYTE_W-1:0] ONE_INNER   = 8'd7;
  localparam logic [BYTE_W-1:0] MUTE_BYTE   = 8'd1;
  localparam logic [BYTE_W-1:0] UNMUTE_BYTE = 8'd0;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [CMD_W-1:0]        kind;
    logic [DIVIDER_BITS-1:0] divider;
    logic                    muted;
    logic                    sig;
    logic [FREQ_W-1:0]       freq;
  } tpl_entry_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  byte_a;
    logic [BYTE_W-1:0]  byte_b;
    logic [BYTE_W-1:0]  byte_c;
    logic [COUNT_W-1:0] count;
    logic               last;
    logic               sig;
    logic [FREQ_W-1:0]  freq;
  } tpl_result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tpl_qstat_t;

endpackage

@@ sv/tuner_pll_serial_loader.sv @@
// ----------------------------------------------------------------------------
// tuner_pll_serial_loader
// turns tuner commands into the port write groups that load a radio card's
// synthesizer, and answers signal and frequency reads
//
//   channel   ports                                   direction
//   in        in_valid, in_stall, in_cmd,             command requests
//             in_freq_in, in_status_byte
//   out       out_valid, out_stall, out_port_byte_*,  result requests
//             out_byte_count, out_last,
//             out_signal_present, out_freq_out
//
// set frequency gives 1 + LEAD_ZERO_BITS + DIVIDER_BITS + 1 results (27),
// one per unstalled cycle from the serializer in the back; other commands give
// at most one result; a two-entry queue parts the front from the back, so
// commands are taken while the serializer runs until the queue fills
// a taken command is written to the queue, then popped into the output register
// rst_n clears mute to set, stored frequency to zero, queue and output empty
// ----------------------------------------------------------------------------
module tuner_pll_serial_loader (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tpl_pkg::CMD_W-1:0]     in_cmd,
  input  logic [tpl_pkg::FREQ_W-1:0]    in_freq_in,
  input  logic [tpl_pkg::STATUS_W-1:0]  in_status_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tpl_pkg::BYTE_W-1:0]    out_port_byte_a,
  output logic [tpl_pkg::BYTE_W-1:0]    out_port_byte_b,
  output logic [tpl_pkg::BYTE_W-1:0]    out_port_byte_c,
  output logic [tpl_pkg::COUNT_W-1:0]   out_byte_count,
  output logic                          out_last,
  output logic                          out_signal_present,
  output logic [tpl_pkg::FREQ_W-1:0]    out_freq_out
);
  import tpl_pkg::*;

  tpl_qstat_t qstat;
  tpl_entry_t push_data;
  tpl_entry_t head;
  logic       push;
  logic       pop;

  tpl_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_freq_in     (in_freq_in),
    .in_status_byte (in_status_byte),
    .qstat          (qstat),
    .push           (push),
    .push_data      (push_data)
  );

  tpl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  tpl_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .qstat              (qstat),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_port_byte_a    (out_port_byte_a),
    .out_port_byte_b    (out_port_byte_b),
    .out_port_byte_c    (out_port_byte_c),
    .out_byte_count     (out_byte_count),
    .out_last           (out_last),
    .out_signal_present (out_signal_present),
    .out_freq_out       (out_freq_out)
  );

  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(qstat.full && qstat.empty))
    else $error("queue full and empty at once");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> qstat.full)
    else $error("input stalled with room in queue");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("serializer gap inside a run");

  a_read_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_count == '0 |-> out_last)
    else $error("read result not marked last");

  a_sig_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_signal_present |-> out_byte_count == '0)
    else $error("signal flag on a port write group");

endmodule

@@ sv/tpl_queue.sv @@
// ----------------------------------------------------------------------------
// tpl_queue
// short fifo of classified requests between the front and the back
// ----------------------------------------------------------------------------
module tpl_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tpl_pkg::tpl_entry_t push_data,
  input  logic                pop,
  output tpl_pkg::tpl_entry_t head,
  output tpl_pkg::tpl_qstat_t stat
);
  import tpl_pkg::*;

  tpl_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = QCNT_W'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = QCNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ sv/tpl_front.sv @@
// ----------------------------------------------------------------------------
// tpl_front
// accepts commands, keeps mute and frequency state, forms the divider and
// queues the requests that give results
// ----------------------------------------------------------------------------
module tpl_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tpl_pkg::CMD_W-1:0]      in_cmd,
  input  logic [tpl_pkg::FREQ_W-1:0]     in_freq_in,
  input  logic [tpl_pkg::STATUS_W-1:0]   in_status_byte,
  input  tpl_pkg::tpl_qstat_t            qstat,
  output logic                           push,
  output tpl_pkg::tpl_entry_t            push_data
);
  import tpl_pkg::*;

  logic                  muted_r, muted_nxt;
  logic [FREQ_W-1:0]     freq_r, freq_nxt;
  logic                  accept;
  logic [PROD_W-1:0]     prod;
  logic [QUOT_W-1:0]     quot;
  logic [DIV_FULL_W-1:0] div_full;
  logic [DIV_EXT_W-1:0]  div_ext;

  assign in_stall = qstat.full;
  assign accept   = in_valid && !in_stall;

  // divide by 200, then add DIV_OFFSET
  assign prod     = PROD_W'(in_freq_in[FREQ_W-1:3]) * PROD_W'(RECIP_25);
  assign quot     = prod[RECIP_SH +: QUOT_W];
  assign div_full = DIV_FULL_W'(quot) + DIV_OFFSET;
  assign div_ext  = DIV_EXT_W'(div_full);

  always_comb begin
    muted_nxt = muted_r;
    freq_nxt  = freq_r;
    push      = 1'b0;
    push_data.kind    = in_cmd;
    push_data.divider = div_ext[DIVIDER_BITS-1:0];
    push_data.muted   = muted_r;
    push_data.sig     = !in_status_byte[1];
    push_data.freq    = freq_r;
    if (accept) begin
      case (in_cmd)
        CMD_SET_FREQ: begin
          push     = 1'b1;
          freq_nxt = in_freq_in;
        end
        CMD_MUTE: begin
          push      = !muted_r;
          muted_nxt = 1'b1;
        end
        CMD_UNMUTE: begin
          push      = muted_r;
          muted_nxt = 1'b0;
        end
        CMD_READ_SIG: begin
          push = 1'b1;
        end
        CMD_READ_FREQ: begin
          push = 1'b1;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      muted_r <= 1'b1;
      freq_r  <= '0;
    end else begin
      muted_r <= muted_nxt;
      freq_r  <= freq_nxt;
    end
  end

endmodule

@@ sv/tpl_back.sv @@
// ----------------------------------------------------------------------------
// tpl_back
// takes queued requests and emits the port write groups and read results,
// serializing the synthesizer load one group per unstalled cycle into an output register
// ----------------------------------------------------------------------------
module tpl_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tpl_pkg::tpl_entry_t           head,
  input  tpl_pkg::tpl_qstat_t           qstat,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tpl_pkg::BYTE_W-1:0]    out_port_byte_a,
  output logic [tpl_pkg::BYTE_W-1:0]    out_port_byte_b,
  output logic [tpl_pkg::BYTE_W-1:0]    out_port_byte_c,
  output logic [tpl_pkg::COUNT_W-1:0]   out_byte_count,
  output logic                          out_last,
  output logic                          out_signal_present,
  output logic [tpl_pkg::FREQ_W-1:0]    out_freq_out
);
  import tpl_pkg::*;

  logic                    busy_r, busy_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [DIVIDER_BITS-1:0] shift_r, shift_nxt;
  logic                    muted_r, muted_nxt;
  logic                    out_valid_r, out_valid_nxt;
  tpl_result_t             res_r, res_nxt;
  logic                    load;

  assign load = !out_valid_r || !out_stall;

  function automatic tpl_result_t bit_group(input logic one);
    tpl_result_t r;
    r        = '0;
    r.byte_a = one ? ONE_OUTER : ZERO_OUTER;
    r.byte_b = one ? ONE_INNER : ZERO_INNER;
    r.byte_c = one ? ONE_OUTER : ZERO_OUTER;
    r.count  = 2'd3;
    return r;
  endfunction

  always_comb begin
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    shift_nxt     = shift_r;
    muted_nxt     = muted_r;
    out_valid_nxt = out_valid_r && out_stall;
    res_nxt       = res_r;
    pop           = 1'b0;
    if (load && busy_r) begin
      out_valid_nxt = 1'b1;
      step_nxt      = STEP_W'(step_r + 1'b1);
      if (step_r == STEP_W'(TRAIL_STEP_I)) begin
        res_nxt        = '0;
        res_nxt.byte_a = TRAIL_BYTE;
        res_nxt.count  = muted_r ? 2'd1 : 2'd2;
        res_nxt.last   = 1'b1;
        busy_nxt       = 1'b0;
      end else if (step_r <= STEP_W'(LEAD_ZERO_BITS)) begin
        res_nxt = bit_group(1'b0);
      end else begin
        res_nxt   = bit_group(shift_r[DIVIDER_BITS-1]);
        shift_nxt = {shift_r[DIVIDER_BITS-2:0], 1'b0};
      end
    end else if (load && !qstat.empty) begin
      pop           = 1'b1;
      out_valid_nxt = 1'b1;
      res_nxt       = '0;
      res_nxt.last  = 1'b1;
      case (head.kind)
        CMD_SET_FREQ: begin
          res_nxt.byte_a = PRE_BYTE_A;
          res_nxt.byte_b = PRE_BYTE_B;
          res_nxt.byte_c = PRE_BYTE_B;
          res_nxt.count  = 2'd3;
          res_nxt.last   = 1'b0;
          busy_nxt       = 1'b1;
          step_nxt       = STEP_W'(1);
          shift_nxt      = head.divider;
          muted_nxt      = head.muted;
        end
        CMD_MUTE: begin
          res_nxt.byte_a = MUTE_BYTE;
          res_nxt.count  = 2'd1;
        end
        CMD_UNMUTE: begin
          res_nxt.byte_a = UNMUTE_BYTE;
          res_nxt.count  = 2'd1;
        end
        CMD_READ_SIG: begin
          res_nxt.sig = head.sig;
        end
        CMD_READ_FREQ: begin
          res_nxt.freq = head.freq;
        end
        default: begin
          res_nxt.last = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    muted_r <= muted_nxt;
    res_r   <= res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_port_byte_a    = res_r.byte_a;
  assign out_port_byte_b    = res_r.byte_b;
  assign out_port_byte_c    = res_r.byte_c;
  assign out_byte_count     = res_r.count;
  assign out_last           = res_r.last;
  assign out_signal_present = res_r.sig;
  assign out_freq_out       = res_r.freq;

endmodule
